// ----- sv/bhkv_pkg.sv -----
`timescale 1ns / 1ps
package bhkv_pkg;
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ = 2'd1,
        CMD_READ_ALL = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_EMPTY = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_RD, S_WAIT, S_CHECK, S_EMIT,
        S_SHIFT_RD, S_SHIFT_WAIT, S_SHIFT_WR, S_PUT, S_RESP
    } t_state;

    localparam logic [31:0] HASH_MULT = 32'd31;
    localparam int RESULT_LIMIT = 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_init;    // start clear sweep
        logic clr_step;    // write zero and advance sweep
        logic load;        // latch command fields, reset hash
        logic hash_step;   // fold one key byte or step the bucket reduction
        logic way_rst;     // way counter to zero
        logic way_inc;     // way counter up
        logic rd;          // issue memory read at current way
        logic shift_wr;    // write read entry one way down
        logic put;         // write new entry at current way
        logic hold;        // keep the matching value just read
        logic emit;        // load output register
        t_status emit_st;
        logic emit_val;    // take value from the held match
        logic emit_last;
        logic cnt_inc;     // result counter up
    } t_ctl;

    typedef struct packed {
        logic clr_done;
        logic hash_done;
        logic way_last;
        logic way_end;     // way counter past last way
        logic slot_empty;
        logic slot_match;
        logic key_empty;
        logic val_empty;
        logic cnt_full;    // one match short of the result limit
        logic found;       // a match is held
        logic out_busy;    // output register holds an untaken result
        t_cmd cmd;
    } t_sts;
endpackage

// ----- sv/bhkv_datapath.sv -----
`timescale 1ns / 1ps
module bhkv_datapath #(
    parameter int NUM_BUCKETS = 256,
    parameter int BUCKET_WAYS = 8,
    parameter int KEY_BYTES = 8,
    parameter int VALUE_BITS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [129:0]    i_in_data,
    input  bhkv_pkg::t_ctl  i_ctl,
    output bhkv_pkg::t_sts  o_sts,
    input  logic            i_out_take,
    output logic            o_out_valid,
    output logic [71:0]     o_out_data,
    output logic            o_out_last
);
    import bhkv_pkg::*;

    localparam int DEPTH = NUM_BUCKETS * BUCKET_WAYS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int WW = $clog2(BUCKET_WAYS + 1);
    localparam int CW = $clog2(RESULT_LIMIT + 1);
    localparam bit BPOW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
    // Rounded-up reciprocal of the bucket count; exact for any 32-bit hash.
    localparam logic [32:0] RECIP = 33'(((64'd1 << (32 + BW)) + 64'(NUM_BUCKETS - 1))
                                        / 64'(NUM_BUCKETS));

    logic [63:0] key_mem [DEPTH];
    logic [63:0] value_mem [DEPTH];

    logic [63:0] w_key_n, w_val_n;
    logic [1:0]  r_cmd, n_cmd;
    logic [63:0] r_key, r_val;
    logic [31:0] r_hash;
    logic [3:0]  r_byte;
    logic [31:0] r_mod;
    logic [64:0] r_prod;
    logic        r_mod_busy;
    logic [WW-1:0] r_way;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_clr;
    logic        r_clr_done;
    logic [63:0] r_rd_key, r_rd_val;
    logic [63:0] r_pend_val;
    logic        r_out_valid;
    logic [1:0]  r_out_st;
    logic [63:0] r_out_val;
    logic        r_out_last;
    logic [BW-1:0] w_bucket;
    logic [AW-1:0] w_addr, w_addr_dn;
    logic [7:0]  w_b;
    logic [31:0] w_quot;

    // Key and value normalisation: clear from the first zero byte; key capped at KEY_BYTES, value at VALUE_BITS.
    always_comb begin
        logic stop_k;
        logic stop_v;
        logic [63:0] vm;
        stop_k = 1'b0;
        stop_v = 1'b0;
        w_key_n = '0;
        w_val_n = '0;
        vm = i_in_data[129:66] & ({64{1'b1}} >> (64 - VALUE_BITS));
        for (int i = 0; i < 8; i++) begin
            if (i >= KEY_BYTES || i_in_data[2+8*i +: 8] == 8'd0) stop_k = 1'b1;
            if (!stop_k) w_key_n[8*i +: 8] = i_in_data[2+8*i +: 8];
            if (vm[8*i +: 8] == 8'd0) stop_v = 1'b1;
            if (!stop_v) w_val_n[8*i +: 8] = vm[8*i +: 8];
        end
    end

    assign w_b = r_key[{r_byte[2:0], 3'b000} +: 8];
    assign n_cmd = i_in_data[1:0];
    assign w_quot = 32'(r_prod >> (32 + BW));

    // Bucket index: the hash reduced modulo the bucket count. For a power of
    // two this is a mask; otherwise a reciprocal multiply, registered in r_prod, then r_mod.
    always_comb begin
        if (BPOW2) begin
            w_bucket = BW'(r_hash);
        end else begin
            w_bucket = BW'(r_mod);
        end
    end

    assign w_addr = AW'(w_bucket) * AW'(BUCKET_WAYS) + AW'(r_way);
    assign w_addr_dn = w_addr - AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_done <= 1'b0;
            r_clr <= '0;
            r_out_valid <= 1'b0;
            r_mod_busy <= 1'b0;
        end else begin
            if (i_ctl.clr_init) begin
                r_clr <= '0;
                r_clr_done <= 1'b0;
            end else if (i_ctl.clr_step) begin
                r_clr <= r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) r_clr_done <= 1'b1;
            end
            if (i_ctl.emit) r_out_valid <= 1'b1;
            else if (i_out_take) r_out_valid <= 1'b0;
            if (i_ctl.load) begin
                r_mod_busy <= 1'b0;
            end else if (i_ctl.hash_step && r_byte == 4'd8 && !r_mod_busy) begin
                r_mod_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_step) key_mem[r_clr] <= '0;
        else if (i_ctl.shift_wr) begin
            key_mem[w_addr_dn] <= r_rd_key;
            value_mem[w_addr_dn] <= r_rd_val;
        end else if (i_ctl.put) begin
            key_mem[w_addr] <= r_key;
            value_mem[w_addr] <= r_val;
        end
        if (i_ctl.rd) begin
            r_rd_key <= key_mem[w_addr];
            r_rd_val <= value_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= n_cmd;
            r_key <= w_key_n;
            r_val <= w_val_n;
            r_hash <= '0;
            r_byte <= '0;
            r_cnt <= '0;
        end else if (i_ctl.hash_step) begin
            if (r_byte < 4'd8) begin
                if (w_b != 8'd0) begin
                    r_hash <= r_hash * HASH_MULT + {{24{w_b[7]}}, w_b};
                    r_byte <= r_byte + 4'd1;
                end else begin
                    r_byte <= 4'd8;
                end
            end else if (!r_mod_busy) begin
                r_prod <= r_hash * RECIP;
                r_byte <= 4'd9;
            end else if (r_byte == 4'd9) begin
                r_mod <= r_hash - w_quot * 32'(NUM_BUCKETS);
                r_byte <= 4'd10;
            end
        end
        if (i_ctl.cnt_inc) r_cnt <= r_cnt + CW'(1);
        if (i_ctl.way_rst) r_way <= '0;
        else if (i_ctl.way_inc) r_way <= r_way + WW'(1);
        if (i_ctl.hold) r_pend_val <= r_rd_val;
        if (i_ctl.emit) begin
            r_out_st <= i_ctl.emit_st;
            r_out_val <= i_ctl.emit_val ? r_pend_val : 64'd0;
            r_out_last <= i_ctl.emit_last;
        end
    end

    always_comb begin
        o_sts.clr_done   = r_clr_done;
        o_sts.hash_done  = r_mod_busy && (BPOW2 || r_byte == 4'd10);
        o_sts.way_last   = r_way == WW'(BUCKET_WAYS - 1);
        o_sts.way_end    = r_way == WW'(BUCKET_WAYS);
        o_sts.slot_empty = r_rd_key == 64'd0;
        o_sts.slot_match = r_rd_key == r_key;
        o_sts.key_empty  = r_key == 64'd0;
        o_sts.val_empty  = r_val == 64'd0;
        o_sts.cnt_full   = r_cnt == CW'(RESULT_LIMIT - 1);
        o_sts.found      = r_cnt != '0;
        o_sts.out_busy   = r_out_valid;
        o_sts.cmd        = t_cmd'(r_cmd);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = {6'd0, r_out_val, r_out_st};
    assign o_out_last = r_out_last;
endmodule

// ----- sv/bhkv_ctrl.sv -----
`timescale 1ns / 1ps
module bhkv_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_fire,
    input  logic            i_enable,
    input  bhkv_pkg::t_sts  i_sts,
    output bhkv_pkg::t_ctl  o_ctl,
    output logic            o_in_ready
);
    import bhkv_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (i_sts.clr_done) n_state = S_IDLE;
            S_IDLE: if (i_in_fire) n_state = S_HASH;
            S_HASH: begin
                if (i_sts.cmd == CMD_NONE) n_state = S_IDLE;
                else if (!i_enable || i_sts.key_empty) n_state = S_RESP;
                else if (i_sts.cmd == CMD_WRITE && i_sts.val_empty) n_state = S_RESP;
                else if (i_sts.hash_done) n_state = S_RD;
            end
            S_RD: n_state = S_WAIT;
            S_WAIT: n_state = S_CHECK;
            S_CHECK: begin
                if (i_sts.cmd == CMD_WRITE) begin
                    if (i_sts.slot_empty) n_state = S_PUT;
                    else if (i_sts.way_last) n_state = S_SHIFT_RD;
                    else n_state = S_RD;
                end else if (i_sts.slot_empty) begin
                    n_state = S_RESP;
                end else if (i_sts.slot_match) begin
                    n_state = S_EMIT;
                end else if (i_sts.way_last) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_RD;
                end
            end
            S_EMIT: if (!(i_sts.found && i_sts.out_busy)) begin
                if (i_sts.cmd == CMD_READ || i_sts.way_last || i_sts.cnt_full)
                    n_state = S_RESP;
                else n_state = S_RD;
            end
            S_SHIFT_RD: n_state = i_sts.way_last ? S_PUT : S_SHIFT_WAIT;
            S_SHIFT_WAIT: n_state = S_SHIFT_WR;
            S_SHIFT_WR: n_state = i_sts.way_last ? S_PUT : S_SHIFT_RD;
            S_PUT: n_state = S_RESP;
            S_RESP: if (!i_sts.out_busy) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // A match is held until the next one turns up or the scan ends, so the
    // last flag is known when the held match is sent; the final one leaves
    // from the response state.
    always_comb begin
        o_ctl = '0;
        o_ctl.emit_st = ST_OK;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_ctl.clr_step = 1'b1;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.load = i_in_fire;
                o_ctl.way_rst = 1'b1;
            end
            S_HASH: o_ctl.hash_step = 1'b1;
            S_RD: o_ctl.rd = 1'b1;
            S_WAIT: ;
            S_CHECK: begin
                if (i_sts.cmd == CMD_WRITE) begin
                    if (!i_sts.slot_empty && !i_sts.way_last) o_ctl.way_inc = 1'b1;
                    if (!i_sts.slot_empty && i_sts.way_last) begin
                        o_ctl.way_rst = 1'b1;
                    end
                end else if (!i_sts.slot_empty && !i_sts.slot_match
                             && !i_sts.way_last) begin
                    o_ctl.way_inc = 1'b1;
                end
            end
            S_EMIT: if (!(i_sts.found && i_sts.out_busy)) begin
                o_ctl.hold = 1'b1;
                o_ctl.cnt_inc = 1'b1;
                o_ctl.way_inc = 1'b1;
                if (i_sts.found) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.emit_val = 1'b1;
                end
            end
            // Each shift step moves to the next way first, reads it and
            // writes it one way down.
            S_SHIFT_RD: if (!i_sts.way_last) o_ctl.way_inc = 1'b1;
            S_SHIFT_WAIT: o_ctl.rd = 1'b1;
            S_SHIFT_WR: o_ctl.shift_wr = 1'b1;
            S_PUT: o_ctl.put = 1'b1;
            S_RESP: if (!i_sts.out_busy) begin
                o_ctl.emit = 1'b1;
                o_ctl.emit_last = 1'b1;
                o_ctl.emit_val = i_sts.found;
                if (!i_enable) o_ctl.emit_st = ST_NOT_READY;
                else if (i_sts.key_empty) o_ctl.emit_st = ST_EMPTY;
                else if (i_sts.cmd == CMD_WRITE)
                    o_ctl.emit_st = i_sts.val_empty ? ST_EMPTY : ST_OK;
                else o_ctl.emit_st = i_sts.found ? ST_OK : ST_NOT_FOUND;
            end
            default: ;
        endcase
    end
endmodule

// ----- sv/bucketed_hash_key_value_store.sv -----
`timescale 1ns / 1ps
// Time from acceptance to the last result, not counting output stalls, is set by
// the serial hash (one key byte a cycle), the bucket reduction, a read per way
// through S_RD, S_WAIT and S_CHECK and, for a full-bucket write, a shift per way
// through S_SHIFT_RD, S_SHIFT_WAIT and S_SHIFT_WR on the single memory port.
// Throughput: one command at a time; the next is taken on return to idle.
// Reset (i_rst_n low, synchronous) clears control state, then a sweep over all
// NUM_BUCKETS*BUCKET_WAYS entries zeroes the key memory before any command.
module bucketed_hash_key_value_store #(
    parameter int NUM_BUCKETS = 256,
    parameter int BUCKET_WAYS = 8,
    parameter int KEY_BYTES = 8,
    parameter int VALUE_BITS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // cmd[1:0], key[65:2], value[129:66]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,  // status[1:0], value_out[65:2]
    output logic         m_axis_tlast
);
    import bhkv_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;
    logic r_enable;
    logic w_in_fire;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_enable <= 1'b0;
        else if (i_cfg_valid) r_enable <= i_cfg_data;
    end

    assign w_in_fire = s_axis_tvalid && s_axis_tready;

    bhkv_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_in_fire),
        .i_enable(r_enable), .i_sts(w_sts), .o_ctl(w_ctl),
        .o_in_ready(s_axis_tready)
    );

    bhkv_datapath #(
        .NUM_BUCKETS(NUM_BUCKETS), .BUCKET_WAYS(BUCKET_WAYS),
        .KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_data(s_axis_tdata[129:0]),
        .i_ctl(w_ctl), .o_sts(w_sts),
        .i_out_take(m_axis_tvalid && m_axis_tready),
        .o_out_valid(m_axis_tvalid), .o_out_data(m_axis_tdata),
        .o_out_last(m_axis_tlast)
    );
endmodule

// ----- sv/bhkv_checker.sv -----
`timescale 1ns / 1ps
module bhkv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    import bhkv_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tlast)
        else $error("error result without last");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[65:2] == 64'd0)
        else $error("error result with nonzero value");

    a_accept_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second command accepted while busy");
endmodule

bind bucketed_hash_key_value_store bhkv_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);
